// File: hdl/scfe_pkg.sv
// ----------------------------------------------------------------------------
// scfe_pkg
// Shared widths, codes and defaults of the slice cache with FIFO eviction.
// ----------------------------------------------------------------------------
`default_nettype none

package scfe_pkg;

  localparam int ROW_W    = 2;
  localparam int COL_W    = 2;
  localparam int IDX_W    = 20;
  localparam int HANDLE_W = 32;
  localparam int STAT_W   = 32;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam int ROWS_DEF  = 4;
  localparam int COLS_DEF  = 4;
  localparam int SLOTS_DEF = 256;

  localparam logic KIND_STORE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic REG_CACHE_ENABLE = 1'b0;

  localparam logic [IDX_W-1:0] TAG_NONE = '1;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [IDX_W-1:0]    tag;
  } slot_ent_t;

  localparam int SLOT_ENT_W = HANDLE_W + IDX_W;

endpackage

`default_nettype wire

// File: hdl/scfe_in_if.sv
// ----------------------------------------------------------------------------
// scfe_in_if
// Request channel of the slice cache: valid, ready and one request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface scfe_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [scfe_pkg::ROW_W-1:0]     tile_row;
  logic [scfe_pkg::COL_W-1:0]     tile_col;
  logic [scfe_pkg::IDX_W-1:0]     slice_index;
  logic [scfe_pkg::HANDLE_W-1:0]  handle_in;

  modport source (output valid, kind, tile_row, tile_col, slice_index, handle_in,
                  input ready);
  modport sink   (input valid, kind, tile_row, tile_col, slice_index, handle_in,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/scfe_out_if.sv
// ----------------------------------------------------------------------------
// scfe_out_if
// Result channel of the slice cache: valid, ready and one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface scfe_out_if;
  logic                           valid;
  logic                           ready;
  logic                           done_res;
  logic [scfe_pkg::HANDLE_W-1:0]  handle_out;
  logic                           evicted;
  logic [scfe_pkg::STAT_W-1:0]    hit_count;
  logic [scfe_pkg::STAT_W-1:0]    miss_count;
  logic [scfe_pkg::STAT_W-1:0]    replace_count;

  modport source (output valid, done_res, handle_out, evicted, hit_count, miss_count,
                  replace_count, input ready);
  modport sink   (input valid, done_res, handle_out, evicted, hit_count, miss_count,
                  replace_count, output ready);
endinterface

`default_nettype wire

// File: hdl/scfe_ram.sv
// ----------------------------------------------------------------------------
// scfe_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module scfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/slice_cache_fifo_evict_top.sv
// ----------------------------------------------------------------------------
// slice_cache_fifo_evict_top
// Direct-mapped slice handle cache per tile with FIFO eviction of the oldest
// entry and saturating hit, miss and replacement counters.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Word
// in_if     sink       valid/ready          kind, tile, slice_index, handle_in
// out_if    source     valid/ready          done_res, handle_out, evicted, counts
// APB       slave      psel/penable/pready  cache_enable at byte address 0
//
// Each word passes five steps from acceptance to a valid result: reciprocal
// multiply, remainder, address build with the queue read, slot memory access,
// and the result load. The next word is taken the cycle after, so one word is
// in work at a time. A store that evicts uses the slot memory twice, once to
// clear the evicted slot, once to write the new entry; other accepted stores
// only write it. After reset a clearing pass writes every slot entry while no
// word is accepted. A stalled result holds the block in its last step, before
// the new slot entry is written; the next word is taken after the result load.
// ----------------------------------------------------------------------------
`default_nettype none

module slice_cache_fifo_evict_top #(
  parameter int ROWS  = scfe_pkg::ROWS_DEF,
  parameter int COLS  = scfe_pkg::COLS_DEF,
  parameter int SLOTS = scfe_pkg::SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  scfe_in_if.sink                          in_if,
  scfe_out_if.source                       out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [scfe_pkg::APB_AW-1:0] paddr,
  input  wire logic [scfe_pkg::APB_DW-1:0] pwdata,
  output logic      [scfe_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);

  import scfe_pkg::*;

  localparam int TILES   = ROWS * COLS;
  localparam int TILE_W  = (TILES > 1) ? $clog2(TILES) : 1;
  localparam int DEPTH   = TILES * SLOTS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PTR_W   = $clog2(SLOTS);
  localparam int FILL_W  = $clog2(SLOTS + 1);
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int PROD_W  = 2 * IDX_W;
  localparam int RECIP   = (1 << IDX_W) / SLOTS;
  localparam int DIM_W   = 8;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_REM  = 3'd3;
  localparam logic [2:0] ST_ADDR = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_r, clr_nxt;
  logic                enable_r, enable_nxt;

  logic                kind_r;
  logic                ok_r;
  logic [TILE_W-1:0]   tile_r;
  logic [IDX_W-1:0]    idx_r;
  logic [HANDLE_W-1:0] hin_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SLOT_W:0]     rem_r;
  logic [ADDR_W-1:0]   addr_r;
  logic                evict_r;

  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [STAT_W-1:0]   hits_r, hits_nxt;
  logic [STAT_W-1:0]   miss_r, miss_nxt;
  logic [STAT_W-1:0]   repl_r, repl_nxt;

  logic                ov_r, ov_nxt;
  logic                o_done_r;
  logic [HANDLE_W-1:0] o_handle_r;
  logic                o_evict_r;

  logic                slot_we, slot_re;
  logic [ADDR_W-1:0]   slot_waddr;
  slot_ent_t           slot_wdata, slot_rdata;
  logic                q_we, q_re;
  logic [ADDR_W-1:0]   q_rdata;

  logic                accept, load, hit, tile_ok, store_ok;
  logic [IDX_W-1:0]    quo, qd;
  logic [SLOT_W-1:0]   slot;
  logic [TILE_W-1:0]   tile_in;

  assign accept   = in_if.valid && in_if.ready;
  assign load     = (state_r == ST_FIN) && (!ov_r || out_if.ready);
  assign store_ok = (kind_r == KIND_STORE) && ok_r;
  assign hit      = (kind_r == KIND_LOOKUP) && ok_r && (slot_rdata.handle != '0) &&
                    (slot_rdata.tag == idx_r);

  assign tile_ok  = (DIM_W'(in_if.tile_row) < DIM_W'(ROWS)) &&
                    (DIM_W'(in_if.tile_col) < DIM_W'(COLS));
  assign tile_in  = TILE_W'(TILE_W'(in_if.tile_row) * TILE_W'(COLS) +
                    TILE_W'(in_if.tile_col));
  assign quo      = prod_r[PROD_W-1:IDX_W];
  assign qd       = IDX_W'(quo * IDX_W'(SLOTS));
  assign slot     = (rem_r >= (SLOT_W+1)'(SLOTS)) ? SLOT_W'(rem_r - (SLOT_W+1)'(SLOTS))
                                                 : SLOT_W'(rem_r);

  assign in_if.ready = (state_r == ST_IDLE);
  assign pready      = 1'b1;
  assign prdata      = APB_DW'(enable_r);

  always_comb begin
    enable_nxt = enable_r;
    if (psel && penable && pwrite && (paddr[2] == REG_CACHE_ENABLE)) begin
      enable_nxt = pwdata[0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_waddr = addr_r;
    slot_wdata = '{handle: hin_r, tag: idx_r};
    q_we       = 1'b0;
    q_re       = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_r;
        slot_wdata = '{handle: '0, tag: TAG_NONE};
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_REM;
      ST_REM:  state_nxt = ST_ADDR;
      ST_ADDR: begin
        q_re      = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        slot_re = (kind_r == KIND_LOOKUP);
        if (store_ok) begin
          q_we = 1'b1;
          if (evict_r) begin
            slot_we    = 1'b1;
            slot_waddr = q_rdata;
            slot_wdata = '{handle: '0, tag: TAG_NONE};
          end
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (load) begin
          slot_we   = store_ok;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    hits_nxt = hits_r;
    miss_nxt = miss_r;
    repl_nxt = repl_r;
    ov_nxt   = ov_r && !out_if.ready;
    if (load) begin
      ov_nxt = 1'b1;
      if (store_ok) begin
        tail_nxt = (tail_r == PTR_W'(SLOTS - 1)) ? '0 : tail_r + 1'b1;
        if (evict_r) begin
          head_nxt = (head_r == PTR_W'(SLOTS - 1)) ? '0 : head_r + 1'b1;
          repl_nxt = (repl_r == '1) ? repl_r : repl_r + 1'b1;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      if (kind_r == KIND_LOOKUP) begin
        if (hit) begin
          hits_nxt = (hits_r == '1) ? hits_r : hits_r + 1'b1;
        end else begin
          miss_nxt = (miss_r == '1) ? miss_r : miss_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      clr_r    <= '0;
      enable_r <= 1'b1;
      head_r   <= '0;
      tail_r   <= '0;
      fill_r   <= '0;
      hits_r   <= '0;
      miss_r   <= '0;
      repl_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      enable_r <= enable_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      hits_r   <= hits_nxt;
      miss_r   <= miss_nxt;
      repl_r   <= repl_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_if.kind;
      ok_r   <= enable_r && tile_ok;
      tile_r <= tile_in;
      idx_r  <= in_if.slice_index;
      hin_r  <= in_if.handle_in;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(idx_r) * PROD_W'(RECIP);
    end
    if (state_r == ST_REM) begin
      rem_r <= (SLOT_W+1)'(idx_r - qd);
    end
    if (state_r == ST_ADDR) begin
      addr_r  <= ADDR_W'(ADDR_W'(tile_r) * ADDR_W'(SLOTS) + ADDR_W'(slot));
      evict_r <= store_ok && (fill_r == FILL_W'(SLOTS));
    end
    if (load) begin
      o_done_r   <= (kind_r == KIND_STORE) ? ok_r : hit;
      o_handle_r <= hit ? slot_rdata.handle : '0;
      o_evict_r  <= evict_r;
    end
  end

  scfe_ram #(.WIDTH(SLOT_ENT_W), .DEPTH(DEPTH)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_en   (slot_re),
    .rd_addr (addr_r),
    .rd_data (slot_rdata)
  );

  scfe_ram #(.WIDTH(ADDR_W), .DEPTH(SLOTS)) u_queue_ram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (tail_r),
    .wr_data (addr_r),
    .rd_en   (q_re),
    .rd_addr (head_r),
    .rd_data (q_rdata)
  );

  assign out_if.valid         = ov_r;
  assign out_if.done_res      = o_done_r;
  assign out_if.handle_out    = o_handle_r;
  assign out_if.evicted       = o_evict_r;
  assign out_if.hit_count     = hits_r;
  assign out_if.miss_count    = miss_r;
  assign out_if.replace_count = repl_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(SLOTS))
    else $error("cached entry count above slot count");

  a_fill_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with differing pointers");

  a_evict_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_evict_r) |-> o_done_r)
    else $error("eviction reported on a refused store");

  a_clr_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> (!in_if.ready && !ov_r))
    else $error("activity during clearing pass");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the slice cache with FIFO eviction against a behavioral predictor.
// Requests are driven from a queue with random sender gaps and receiver
// stalls. Every result word is compared field by field with the predicted
// word, with the cache enable register both set and cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import scfe_pkg::*;

  localparam int NROWS = 4;
  localparam int NCOLS = 4;
  localparam int NSLOTS = 256;
  localparam int WATCH_LIMIT = NROWS * NCOLS * NSLOTS + 20000;

  typedef struct packed {
    logic                kind;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [IDX_W-1:0]    sidx;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic                done;
    logic [HANDLE_W-1:0] handle;
    logic                evicted;
    logic [STAT_W-1:0]   hits;
    logic [STAT_W-1:0]   misses;
    logic [STAT_W-1:0]   replaces;
  } res_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [IDX_W-1:0] sidx;
  } fifo_ent_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic pready;

  scfe_in_if  in_if ();
  scfe_out_if out_if ();

  slice_cache_fifo_evict_top dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state.
  logic [HANDLE_W-1:0] model_handle [NROWS*NCOLS*NSLOTS];
  logic [IDX_W-1:0]    model_tag    [NROWS*NCOLS*NSLOTS];
  fifo_ent_t           model_fifo   [NSLOTS];
  int unsigned         model_head, model_tail, model_total;
  logic [STAT_W-1:0]   model_hits, model_misses, model_replaces;
  logic                model_enable;

  req_t pending_reqs[$];
  res_t expected_words[$];
  int   send_idle_pct, recv_idle_pct;
  int   fail_count, store_count, lookup_count, hit_seen_count, evict_seen_count;
  int   quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [STAT_W-1:0] sat_inc(logic [STAT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic int unsigned slot_of(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                          logic [IDX_W-1:0] s);
    return (int'(r) * NCOLS + int'(c)) * NSLOTS + int'(s) % NSLOTS;
  endfunction

  function automatic res_t predict_cache(req_t q);
    res_t r;
    int unsigned a;
    fifo_ent_t e;
    r = '0;
    if (q.kind == KIND_STORE) begin
      if (model_enable) begin
        if (model_total >= NSLOTS) begin
          e = model_fifo[model_head];
          a = slot_of(e.row, e.col, e.sidx);
          model_handle[a] = '0;
          model_tag[a] = TAG_NONE;
          model_head = (model_head + 1) % NSLOTS;
          model_total--;
          model_replaces = sat_inc(model_replaces);
          r.evicted = 1'b1;
        end
        model_fifo[model_tail] = '{row: q.row, col: q.col, sidx: q.sidx};
        model_tail = (model_tail + 1) % NSLOTS;
        a = slot_of(q.row, q.col, q.sidx);
        model_handle[a] = q.handle;
        model_tag[a] = q.sidx;
        model_total++;
        r.done = 1'b1;
      end
    end else begin
      if (model_enable) begin
        a = slot_of(q.row, q.col, q.sidx);
        if (model_handle[a] != '0 && model_tag[a] == q.sidx) begin
          r.handle = model_handle[a];
          r.done = 1'b1;
        end
      end
      if (r.done) model_hits = sat_inc(model_hits);
      else model_misses = sat_inc(model_misses);
    end
    r.hits = model_hits;
    r.misses = model_misses;
    r.replaces = model_replaces;
    return r;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid       <= 1'b1;
        in_if.kind        <= pending_reqs[0].kind;
        in_if.tile_row    <= pending_reqs[0].row;
        in_if.tile_col    <= pending_reqs[0].col;
        in_if.slice_index <= pending_reqs[0].sidx;
        in_if.handle_in   <= pending_reqs[0].handle;
        expected_words.push_back(predict_cache(pending_reqs.pop_front()));
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor.
  always @(posedge clk) begin
    res_t exp_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_if.done_res !== exp_w.done) begin
          $error("done_res expected %0h got %0h", exp_w.done, out_if.done_res);
          fail_count++;
        end
        if (out_if.handle_out !== exp_w.handle) begin
          $error("handle_out expected %0h got %0h", exp_w.handle, out_if.handle_out);
          fail_count++;
        end
        if (out_if.evicted !== exp_w.evicted) begin
          $error("evicted expected %0h got %0h", exp_w.evicted, out_if.evicted);
          fail_count++;
        end
        if (out_if.hit_count !== exp_w.hits) begin
          $error("hit_count expected %0d got %0d", exp_w.hits, out_if.hit_count);
          fail_count++;
        end
        if (out_if.miss_count !== exp_w.misses) begin
          $error("miss_count expected %0d got %0d", exp_w.misses, out_if.miss_count);
          fail_count++;
        end
        if (out_if.replace_count !== exp_w.replaces) begin
          $error("replace_count expected %0d got %0d", exp_w.replaces,
                 out_if.replace_count);
          fail_count++;
        end
        if (exp_w.evicted) evict_seen_count++;
        if (exp_w.handle != '0) hit_seen_count++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_words.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_enable(logic v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {2'b00, REG_CACHE_ENABLE} << 2;
    pwdata  <= {31'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_enable = v;
  endtask

  task automatic add_req(logic k, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                         logic [IDX_W-1:0] s, logic [HANDLE_W-1:0] h);
    pending_reqs.push_back('{kind: k, row: r, col: c, sidx: s, handle: h});
    if (k == KIND_STORE) store_count++;
    else lookup_count++;
  endtask

  // Random part: stores mostly into indexes 0 to 600, lookups mostly of one of
  // the last 300 stores so that they hit, with full-range noise mixed in.
  task automatic add_random(int n);
    req_t recent[$];
    req_t q;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        q.kind = KIND_STORE;
        q.row = ROW_W'($urandom_range(3));
        q.col = COL_W'($urandom_range(3));
        q.sidx = ($urandom_range(3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(600));
        q.handle = ($urandom_range(15) == 0) ? '0 : HANDLE_W'($urandom);
        recent.push_back(q);
        if (recent.size() > 300) void'(recent.pop_front());
      end else if (pick < 85 && recent.size() > 0) begin
        q = recent[$urandom_range(recent.size() - 1)];
        q.kind = KIND_LOOKUP;
        q.handle = HANDLE_W'($urandom);
      end else begin
        q.kind = KIND_LOOKUP;
        q.row = ROW_W'($urandom_range(3));
        q.col = COL_W'($urandom_range(3));
        q.sidx = IDX_W'($urandom);
        q.handle = HANDLE_W'($urandom);
      end
      add_req(q.kind, q.row, q.col, q.sidx, q.handle);
    end
  endtask

  initial begin
    clk = 1'b0;
    model_head = 0; model_tail = 0; model_total = 0;
    model_hits = '0; model_misses = '0; model_replaces = '0;
    model_enable = 1'b1;
    for (int i = 0; i < NROWS * NCOLS * NSLOTS; i++) begin
      model_handle[i] = '0;
      model_tag[i] = TAG_NONE;
    end
    fail_count = 0; store_count = 0; lookup_count = 0;
    hit_seen_count = 0; evict_seen_count = 0; quiet_cycles = 0;
    send_idle_pct = 9; recv_idle_pct = 61;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.kind = 1'b0; in_if.tile_row = '0; in_if.tile_col = '0;
    in_if.slice_index = '0; in_if.handle_in = '0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_enable(1'b1);
    add_req(KIND_STORE, 2'd0, 2'd0, 20'd0, 32'hFFFF_FFFF);
    add_req(KIND_LOOKUP, 2'd0, 2'd0, 20'd0, 32'h0);
    add_req(KIND_STORE, 2'd3, 2'd3, 20'hFFFFF, 32'h0000_0001);
    add_req(KIND_LOOKUP, 2'd3, 2'd3, 20'hFFFFF, 32'hFFFF_FFFF);
    add_req(KIND_LOOKUP, 2'd3, 2'd3, 20'h000FF, 32'h0);
    add_req(KIND_STORE, 2'd1, 2'd2, 20'h00105, 32'h0);
    add_req(KIND_LOOKUP, 2'd1, 2'd2, 20'h00105, 32'h0);
    add_req(KIND_STORE, 2'd1, 2'd2, 20'h00205, 32'hA5A5_5A5A);
    add_req(KIND_LOOKUP, 2'd1, 2'd2, 20'h00105, 32'h0);
    add_req(KIND_LOOKUP, 2'd1, 2'd2, 20'h00205, 32'h0);
    add_req(KIND_LOOKUP, 2'd2, 2'd1, 20'h00205, 32'h0);
    wait_idle();

    write_enable(1'b0);
    add_req(KIND_STORE, 2'd0, 2'd1, 20'd7, 32'h1234_5678);
    add_req(KIND_LOOKUP, 2'd0, 2'd0, 20'd0, 32'h0);
    add_req(KIND_LOOKUP, 2'd0, 2'd1, 20'd7, 32'h0);
    wait_idle();

    write_enable(1'b1);
    add_req(KIND_LOOKUP, 2'd0, 2'd0, 20'd0, 32'h0);
    add_random(560);
    wait_idle();

    send_idle_pct = 61; recv_idle_pct = 9;
    write_enable(1'b0);
    add_random(40);
    wait_idle();
    write_enable(1'b1);
    add_random(520);
    wait_idle();

    send_idle_pct = 0; recv_idle_pct = 0;
    add_random(500);
    wait_idle();

    $display("Covered %0d stores and %0d lookups; %0d hits and %0d evictions checked.",
             store_count, lookup_count, hit_seen_count, evict_seen_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// File: slice_cache_fifo_evict_top.f
hdl/scfe_pkg.sv
hdl/scfe_in_if.sv
hdl/scfe_out_if.sv
hdl/scfe_ram.sv
hdl/slice_cache_fifo_evict_top.sv
tb/sv/tb_top.sv
